FILE: src/rle_pkg.sv
`timescale 1ns / 1ps
package rle_pkg;

	localparam int CNT_W = 25;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] MAX_RUN = 8'd255;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] BLOCK_LENGTH_RST = 25'd16777216;

	typedef struct packed {
		logic             ovf;
		logic             eob;
		logic [CNT_W-1:0] count;
		logic [7:0]       value;
		logic [7:0]       len;
	} pair_t;

	typedef struct packed {
		logic  two;
		pair_t p1;
		pair_t p0;
	} group_t;

	function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W:0] x);
		sat_cnt = x[CNT_W] ? CNT_MAX : x[CNT_W-1:0];
	endfunction

endpackage

FILE: src/rle_pair_encoder_core.sv
`timescale 1ns / 1ps
// Run-length pair encoder.
// Input stream: one source byte per beat on s_axis_tdata, s_axis_tlast marks
// the final byte of a block. Output stream: one (length, value) pair per beat
// with the running output byte count; m_axis_tuser flags an overflow and
// m_axis_tlast marks the final pair of a block (also set on overflow, after
// which the rest of the block is dropped up to the input tlast).
// cfg_we/cfg_wdata load the block length; write it only while idle.
// Throughput: one input byte per cycle. A byte that yields two pairs holds
// the output for both pairs, which the four-entry pair queue between the
// run tracker and the output stage absorbs; the input stalls only when that
// queue is full.
// A pair reaches m_axis through the queue, written at the input beat, and
// then the output register, loaded from the queue head once it is free.
// Reset clears the run state, empties the queue and the output register and
// sets the block length to 2^24. When the receiver stalls, the current pair
// holds on m_axis and input keeps flowing until the queue fills.
module rle_pair_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [24:0] cfg_wdata,     // block_length
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic        s_axis_tlast,  // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // run_length[7:0], run_value[15:8],
	                                   // compressed_bytes[40:16], zero[47:41]
	output logic        m_axis_tuser,  // overflow
	output logic        m_axis_tlast   // end_of_block
);

	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_empty;
	rle_pkg::group_t push_group;
	rle_pkg::group_t head_group;
	rle_pkg::pair_t  out_pair;

	rle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.data_byte (s_axis_tdata),
		.last      (s_axis_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_group   (push_group)
	);

	rle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_group (push_group),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.head       (head_group)
	);

	rle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (head_group),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pair  (out_pair)
	);

	assign m_axis_tdata = {7'd0, out_pair.count, out_pair.value, out_pair.len};
	assign m_axis_tuser = out_pair.ovf;
	assign m_axis_tlast = out_pair.eob;

`ifndef SYNTHESIS
	a_ovf_ends_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("overflow pair without end of block");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:0] != 8'd0)
		else $error("pair with zero run length");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into full pair queue");

	a_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty && !m_axis_tvalid && !q_push |=> !m_axis_tvalid)
		else $error("output valid without queued pair");
`endif

endmodule

FILE: src/rle_front.sv
`timescale 1ns / 1ps
module rle_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rle_pkg::CNT_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  data_byte,
	input  logic                        last,
	input  logic                        q_full,
	output logic                        q_push,
	output rle_pkg::group_t             q_group
);

	logic [rle_pkg::CNT_W-1:0] block_length_q;
	logic [7:0]                cur_value_q;
	logic [7:0]                run_count_q;
	logic [rle_pkg::CNT_W-1:0] out_count_q;
	logic                      started_q;
	logic                      failed_q;

	logic                      accept;
	logic                      same;
	logic                      full_run;
	logic                      emit_a;
	logic                      emit_f;
	logic [7:0]                next_value;
	logic [7:0]                next_count;
	logic [rle_pkg::CNT_W:0]   bl_ext;
	logic [rle_pkg::CNT_W:0]   sum_a;
	logic [rle_pkg::CNT_W:0]   sum_4;
	logic [rle_pkg::CNT_W:0]   sum_f;
	logic                      ovf_a;
	logic                      ovf_f;
	rle_pkg::pair_t            pair_a;
	rle_pkg::pair_t            pair_f;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign same     = (data_byte == cur_value_q);
	assign full_run = (run_count_q >= rle_pkg::MAX_RUN);
	assign emit_a   = !failed_q && started_q && (!same || full_run);

	always_comb begin
		if (!started_q || !same) begin
			next_value = data_byte;
			next_count = 8'd1;
		end else begin
			next_value = cur_value_q;
			next_count = full_run ? 8'd1 : run_count_q + 8'd1;
		end
	end

	assign bl_ext = {1'b0, block_length_q};
	assign sum_a  = {1'b0, out_count_q} + 26'd2;
	assign sum_4  = {1'b0, out_count_q} + 26'd4;
	assign ovf_a  = (sum_a >= bl_ext);

	always_comb begin
		if (!emit_a) begin
			sum_f = sum_a;
		end else if (sum_a[rle_pkg::CNT_W]) begin
			sum_f = {1'b0, rle_pkg::CNT_MAX} + 26'd2;
		end else begin
			sum_f = sum_4;
		end
	end

	assign ovf_f  = (sum_f >= bl_ext);
	assign emit_f = !failed_q && last && !(emit_a && ovf_a);

	always_comb begin
		pair_a.len   = run_count_q;
		pair_a.value = cur_value_q;
		pair_a.count = rle_pkg::sat_cnt(sum_a);
		pair_a.ovf   = ovf_a;
		pair_a.eob   = ovf_a;
		pair_f.len   = next_count;
		pair_f.value = next_value;
		pair_f.count = rle_pkg::sat_cnt(sum_f);
		pair_f.ovf   = ovf_f;
		pair_f.eob   = 1'b1;
		if (emit_a) begin
			q_group.p0  = pair_a;
			q_group.p1  = pair_f;
			q_group.two = emit_f;
		end else begin
			q_group.p0  = pair_f;
			q_group.p1  = pair_f;
			q_group.two = 1'b0;
		end
	end

	assign q_push = accept && (emit_a || emit_f);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= rle_pkg::BLOCK_LENGTH_RST;
		end else if (cfg_we) begin
			block_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_value_q <= '0;
			run_count_q <= '0;
			out_count_q <= '0;
			started_q   <= 1'b0;
			failed_q    <= 1'b0;
		end else if (accept) begin
			if (last) begin
				cur_value_q <= '0;
				run_count_q <= '0;
				out_count_q <= '0;
				started_q   <= 1'b0;
				failed_q    <= 1'b0;
			end else if (!failed_q) begin
				cur_value_q <= next_value;
				run_count_q <= next_count;
				started_q   <= 1'b1;
				if (emit_a) begin
					out_count_q <= pair_a.count;
					failed_q    <= ovf_a;
				end
			end
		end
	end

endmodule

FILE: src/rle_queue.sv
`timescale 1ns / 1ps
module rle_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  rle_pkg::group_t             push_group,
	output logic                        full,
	input  logic                        pop,
	output logic                        empty,
	output rle_pkg::group_t             head
);

	rle_pkg::group_t               mem_q [rle_pkg::QUEUE_DEPTH];
	logic [rle_pkg::QUEUE_AW-1:0]  wr_ptr_q;
	logic [rle_pkg::QUEUE_AW-1:0]  rd_ptr_q;
	logic [rle_pkg::QUEUE_AW:0]    count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full    = (count_q == (rle_pkg::QUEUE_AW+1)'(rle_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: src/rle_back.sv
`timescale 1ns / 1ps
module rle_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  rle_pkg::group_t             q_head,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output rle_pkg::pair_t              out_pair
);

	rle_pkg::group_t grp_q;
	logic            valid_q;
	logic            second_q;
	logic            fire;
	logic            group_done;

	assign fire       = valid_q && out_ready;
	assign group_done = second_q || !grp_q.two;
	assign q_pop      = !q_empty && (!valid_q || (fire && group_done));
	assign out_valid  = valid_q;
	assign out_pair   = second_q ? grp_q.p1 : grp_q.p0;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			grp_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (q_pop) begin
			valid_q  <= 1'b1;
			second_q <= 1'b0;
		end else if (fire) begin
			if (group_done) begin
				valid_q  <= 1'b0;
				second_q <= 1'b0;
			end else begin
				second_q <= 1'b1;
			end
		end
	end

endmodule
